// ===== sv/upc_pkg.sv =====
// Shared types, character codes and helper functions for the URL percent codec.
`default_nettype none

package upc_pkg;

   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_DASH    = 8'h2D;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_UNDER   = 8'h5F;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_TILDE   = 8'h7E;
   localparam logic [7:0] CASE_OFFSET  = 8'd32;
   localparam logic [7:0] ALPHA_OFFSET = 8'd87;

   // Number of result slots one request can fill.
   localparam int unsigned MaxResults = 3;

   typedef enum logic [1:0] {
      PHASE_IDLE    = 2'd0,
      PHASE_PERCENT = 2'd1,
      PHASE_HELD    = 2'd2
   } decode_phase_type;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       is_last;
   } req_item_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic       has_byte;
      logic       end_of_string;
   } rsp_item_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic logic is_upper(input logic [7:0] c);
      return (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z);
   endfunction

   function automatic logic is_unreserved(input logic [7:0] c);
      return is_digit(c) || is_upper(c) ||
             ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) ||
             (c == CHAR_DASH) || (c == CHAR_UNDER) ||
             (c == CHAR_DOT) || (c == CHAR_TILDE);
   endfunction

   // Nibble value of an escape character, wrapped to 8 bits for any input byte.
   function automatic logic [7:0] nibble_of(input logic [7:0] c);
      logic [7:0] folded;
      folded = is_upper(c) ? (c + CASE_OFFSET) : c;
      return is_digit(c) ? (c - CHAR_ZERO) : (folded - ALPHA_OFFSET);
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      logic [7:0] r;
      case (v)
         4'h0: r = 8'h30;
         4'h1: r = 8'h31;
         4'h2: r = 8'h32;
         4'h3: r = 8'h33;
         4'h4: r = 8'h34;
         4'h5: r = 8'h35;
         4'h6: r = 8'h36;
         4'h7: r = 8'h37;
         4'h8: r = 8'h38;
         4'h9: r = 8'h39;
         4'hA: r = 8'h41;
         4'hB: r = 8'h42;
         4'hC: r = 8'h43;
         4'hD: r = 8'h44;
         4'hE: r = 8'h45;
         default: r = 8'h46;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/upc_stream_if.sv =====
// Valid/ready stream interface used by the request and response channels.
`default_nettype none

interface upc_stream_if #(
   parameter type payload_type = upc_pkg::req_item_type
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== sv/url_percent_codec.sv =====
// URL percent encoder/decoder with a three-entry response buffer.
//
//   channel   | direction | handshake           | payload
//   ----------+-----------+---------------------+-----------------------------------
//   req_if    | in        | valid/ready         | byte_in[7:0], is_last
//   rsp_if    | out       | valid/ready         | byte_out[7:0], has_byte, end_of_string
//   csr_*     | in        | csr_we, no stall    | csr_wdata = decode_mode
//
// A request is processed in the cycle it is accepted and its results are loaded into
// the response buffer, which drains one result per cycle while rsp_if.ready is high.
// A request yields 0 to 3 results; an encoded escape yields 3.
// The next request is taken while the last buffered result is being delivered.
// Reset is synchronous and empties the buffer and clears the codec state.
// A stalled response holds its data; requests stall until the buffer frees up.
`default_nettype none

module url_percent_codec (
   input  wire logic   clock,
   input  wire logic   reset,
   upc_stream_if.sink  req_if,
   upc_stream_if.source rsp_if,
   input  wire logic   csr_we,
   input  wire logic   csr_wdata
);

   logic                        decode_mode_ff;
   upc_pkg::decode_phase_type   phase_ff, phase_in, phase_mid;
   logic [7:0]                  held_ff, held_in, held_mid;
   logic                        skip_ff, skip_in;
   upc_pkg::rsp_item_type       slot_ff [upc_pkg::MaxResults];
   upc_pkg::rsp_item_type       item    [upc_pkg::MaxResults];
   logic [1:0]                  cnt_ff, cnt_in;
   logic [1:0]                  rd_ff, rd_in;

   logic [7:0]                  main_byte [upc_pkg::MaxResults];
   logic [1:0]                  main_cnt;
   logic                        tail_valid;
   logic [7:0]                  tail_byte;
   logic [1:0]                  num_results;
   logic                        is_end;
   logic [7:0]                  b;
   logic                        last;
   logic                        req_fire, rsp_fire;

   assign b        = req_if.payload.byte_in;
   assign last     = req_if.payload.is_last;
   assign req_fire = req_if.valid && req_if.ready;
   assign rsp_fire = rsp_if.valid && rsp_if.ready;

   assign rsp_if.valid   = (cnt_ff != 2'd0);
   assign rsp_if.payload = slot_ff[rd_ff];
   assign req_if.ready   = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_if.ready);

   // Results of the request at the input port, against the current codec state.
   always_comb begin
      phase_mid   = phase_ff;
      held_mid    = held_ff;
      main_cnt    = 2'd0;
      tail_valid  = 1'b0;
      tail_byte   = upc_pkg::CHAR_NUL;
      num_results = 2'd0;
      is_end      = 1'b0;
      skip_in     = skip_ff;
      phase_in    = phase_ff;
      held_in     = held_ff;
      for (int i = 0; i < upc_pkg::MaxResults; i++) begin
         main_byte[i]           = upc_pkg::CHAR_NUL;
         item[i].byte_out       = upc_pkg::CHAR_NUL;
         item[i].has_byte       = 1'b0;
         item[i].end_of_string  = 1'b0;
      end

      if (skip_ff) begin
         if (last) begin
            skip_in = 1'b0;
         end
      end else begin
         if (b != upc_pkg::CHAR_NUL) begin
            if (!decode_mode_ff) begin
               if (upc_pkg::is_unreserved(b)) begin
                  main_byte[0] = b;
                  main_cnt     = 2'd1;
               end else if (b == upc_pkg::CHAR_SPACE) begin
                  main_byte[0] = upc_pkg::CHAR_PLUS;
                  main_cnt     = 2'd1;
               end else begin
                  main_byte[0] = upc_pkg::CHAR_PERCENT;
                  main_byte[1] = upc_pkg::hex_digit(b[7:4]);
                  main_byte[2] = upc_pkg::hex_digit(b[3:0]);
                  main_cnt     = 2'd3;
               end
            end else begin
               case (phase_ff)
                  upc_pkg::PHASE_PERCENT: begin
                     held_mid  = b;
                     phase_mid = upc_pkg::PHASE_HELD;
                  end
                  upc_pkg::PHASE_HELD: begin
                     main_byte[0] = {upc_pkg::nibble_of(held_ff) << 4} |
                                    upc_pkg::nibble_of(b);
                     main_cnt     = 2'd1;
                     phase_mid    = upc_pkg::PHASE_IDLE;
                     held_mid     = upc_pkg::CHAR_NUL;
                  end
                  default: begin
                     if (b == upc_pkg::CHAR_PERCENT) begin
                        phase_mid = upc_pkg::PHASE_PERCENT;
                     end else if (b == upc_pkg::CHAR_PLUS) begin
                        main_byte[0] = upc_pkg::CHAR_SPACE;
                        main_cnt     = 2'd1;
                     end else begin
                        main_byte[0] = b;
                        main_cnt     = 2'd1;
                     end
                  end
               endcase
            end
         end

         is_end = (b == upc_pkg::CHAR_NUL) || last;

         if (is_end) begin
            // A short escape at the end: the held byte is decoded on its own.
            if (decode_mode_ff && (phase_mid == upc_pkg::PHASE_HELD)) begin
               if (held_mid == upc_pkg::CHAR_PLUS) begin
                  tail_valid = 1'b1;
                  tail_byte  = upc_pkg::CHAR_SPACE;
               end else if (held_mid != upc_pkg::CHAR_PERCENT) begin
                  tail_valid = 1'b1;
                  tail_byte  = held_mid;
               end
            end
            phase_in = upc_pkg::PHASE_IDLE;
            held_in  = upc_pkg::CHAR_NUL;
         end else begin
            phase_in = phase_mid;
            held_in  = held_mid;
         end

         for (int i = 0; i < upc_pkg::MaxResults; i++) begin
            item[i].byte_out = main_byte[i];
            item[i].has_byte = (2'(i) < main_cnt);
         end
         // The tail only occurs in decode mode, where at most one main result exists.
         if (tail_valid && (main_cnt != 2'd3)) begin
            item[main_cnt].byte_out = tail_byte;
            item[main_cnt].has_byte = 1'b1;
         end
         num_results = main_cnt + {1'b0, tail_valid};

         if (is_end) begin
            if (num_results == 2'd0) begin
               item[0].byte_out      = upc_pkg::CHAR_NUL;
               item[0].has_byte      = 1'b0;
               item[0].end_of_string = 1'b1;
               num_results           = 2'd1;
            end else begin
               item[num_results - 2'd1].end_of_string = 1'b1;
            end
         end

         if ((b == upc_pkg::CHAR_NUL) && !last) begin
            skip_in = 1'b1;
         end
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      rd_in  = rd_ff;
      if (req_fire) begin
         cnt_in = num_results;
         rd_in  = 2'd0;
      end else if (rsp_fire) begin
         cnt_in = cnt_ff - 2'd1;
         rd_in  = rd_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decode_mode_ff <= 1'b0;
         phase_ff       <= upc_pkg::PHASE_IDLE;
         held_ff        <= upc_pkg::CHAR_NUL;
         skip_ff        <= 1'b0;
         cnt_ff         <= 2'd0;
         rd_ff          <= 2'd0;
      end else begin
         if (csr_we) begin
            decode_mode_ff <= csr_wdata;
         end
         if (req_fire) begin
            phase_ff <= phase_in;
            held_ff  <= held_in;
            skip_ff  <= skip_in;
         end
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < upc_pkg::MaxResults; i++) begin
            slot_ff[i] <= item[i];
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/upc_checker.sv =====
// Port-level checker for the URL percent codec, bound to the top level.
`default_nettype none

module upc_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire upc_pkg::rsp_item_type rsp_payload
);

   // The response buffer is empty right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response keeps its data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // A result without data is only ever a bare end marker.
   a_bare_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.has_byte |->
         rsp_payload.end_of_string && (rsp_payload.byte_out == upc_pkg::CHAR_NUL))
      else $error("bare result is not an end marker");

   // With nothing buffered, a request is always taken.
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled while the response buffer is empty");

   // A request seen while the buffer is empty is accepted in that cycle.
   a_req_taken: assert property (@(posedge clock) disable iff (reset)
      req_valid && !rsp_valid |-> req_ready)
      else $error("request not taken with an empty buffer");

endmodule

bind url_percent_codec upc_checker u_upc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);

`default_nettype wire
